>>> hw/rtl/jep_pkg.sv
// shared types and constants for the jitter entropy pool with park-miller output
// no dependencies
`default_nettype none

package jep_pkg;

    // sequencer states of the draw engine
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_POP,
        ST_POPD,
        ST_DONE
    } t_state;

    // park-miller minimal standard constants
    localparam logic [14:0] PM_MULT = 15'h41A7;
    localparam logic [30:0] PM_MOD  = 31'h7FFFFFFF;

    // configuration register indexes
    localparam logic REG_SOURCE_MODE = 1'b0;
    localparam logic REG_SEED_INIT   = 1'b1;

    // source modes
    localparam logic MODE_TIMESTAMP = 1'b0;
    localparam logic MODE_ADC       = 1'b1;

    // input request kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    // seed bytes per draw and the step codes of the draw sequence
    localparam logic [2:0] SEED_BYTES    = 3'd4;
    localparam logic [2:0] LAST_FALLBACK = 3'd3;
    localparam logic [2:0] FINAL_STEP    = 3'd4;

endpackage

`default_nettype wire

>>> hw/rtl/jep_pm_unit.sv
// shared park-miller step unit: registered 32x15 product, then mod (2^31 - 1) fold
// depends on jep_pkg
`default_nettype none

module jep_pm_unit
    import jep_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_load,
    input  wire logic [31:0] i_operand,
    output logic      [31:0] o_result
);

    logic [46:0] r_prod;
    logic [31:0] w_sum;
    logic [31:0] w_mod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= 47'(i_operand) * 47'(PM_MULT);
        end
    end

    // 2^31 == 1 mod m, so high part folds onto the low part
    assign w_mod = {1'b0, PM_MOD};
    assign w_sum = 32'(r_prod[46:31]) + {1'b0, r_prod[30:0]};

    always_comb begin
        if (w_sum >= w_mod) begin
            o_result = w_sum - w_mod;
        end else begin
            o_result = w_sum;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/jitter_entropy_pool_with_lcg.sv
// jitter entropy pool: sample tick collection into a byte fifo, park-miller draw engine
// depends on jep_pkg and jep_pm_unit
//
// usage:
//   s_axis carries requests: tuser selects a sample tick or a draw, tdata holds the
//   32-bit timestamp or adc code (ignored on a draw).
//   a sample tick leaves the block in idle and gives no result. a comparison bit is
//   shifted in when the two compared values differ; each full byte goes into a
//   POOL_DEPTH byte fifo, and a byte that meets a full fifo is dropped.
//   a draw gives one result on m_axis: the new 32-bit seed and how many of the
//   four seed bytes came from the pool.
//   in a draw, the single park-miller unit runs five steps (multiply, then fold), and
//   every pool byte costs one memory read. s_axis_tready is low while a draw runs; a
//   sample tick every cycle is sustained between draws. if m_axis stalls, a finished
//   draw waits in its output register and the block keeps taking sample ticks; a second
//   draw holds at its end until the register frees. reset clears seed, pointers, fill
//   level and collector state; pool contents are not cleared and need no clearing pass,
//   since only written bytes are ever read. configuration (source mode, seed load) is
//   written through i_cfg_*; the user must do this only while idle, as the block itself
//   does not enforce it.
`default_nettype none

module jitter_entropy_pool_with_lcg
    import jep_pkg::*;
#(
    parameter int POOL_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] sample
    input  wire logic [0:0]  s_axis_tuser,   // [0] func
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata    // [31:0] random_value, [34:32] pool_bytes_used
);

    localparam int PTR_W  = $clog2(POOL_DEPTH);
    localparam int FILL_W = $clog2(POOL_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(POOL_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(POOL_DEPTH);

    t_state r_state, n_state;

    logic              r_mode;
    logic [31:0]       r_seed;
    logic [31:0]       r_last_sample;
    logic [31:0]       r_last_diff;
    logic [7:0]        r_acc;
    logic [2:0]        r_bit_cnt;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [FILL_W-1:0] r_fill;
    logic [2:0]        r_step;
    logic [2:0]        r_used;
    logic [31:0]       r_bytes;
    logic              r_out_valid;
    logic [31:0]       r_out_value;
    logic [2:0]        r_out_used;

    logic [7:0]        mem [POOL_DEPTH];
    logic [7:0]        r_rd_data;

    logic        w_in_acc;
    logic        w_sample_acc;
    logic        w_draw_acc;
    logic        w_pm_load;
    logic        w_pop;
    logic        w_pop_done;
    logic        w_out_load;
    logic        w_push;
    logic [31:0] w_pm_result;
    logic [31:0] w_diff;
    logic [31:0] w_prev;
    logic [31:0] w_curr;
    logic        w_shift;
    logic [7:0]  w_acc_next;

    jep_pm_unit u_pm (
        .i_clk     (i_clk),
        .i_load    (w_pm_load),
        .i_operand (r_seed),
        .o_result  (w_pm_result)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_draw_acc) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_RED;
            ST_RED: begin
                if (r_step == FINAL_STEP) begin
                    n_state = ST_DONE;
                end else if (r_step == LAST_FALLBACK) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_POP: begin
                if (r_used != SEED_BYTES && r_fill != '0) begin
                    n_state = ST_POPD;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_POPD: n_state = ST_POP;
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_pm_load     = 1'b0;
        w_pop         = 1'b0;
        w_pop_done    = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_MUL:  w_pm_load = 1'b1;
            ST_POP:  w_pop = (r_used != SEED_BYTES) && (r_fill != '0);
            ST_POPD: w_pop_done = 1'b1;
            ST_DONE: w_out_load = !r_out_valid || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign w_sample_acc = w_in_acc && (s_axis_tuser[0] == FUNC_SAMPLE);
    assign w_draw_acc   = w_in_acc && (s_axis_tuser[0] == FUNC_DRAW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- sample collector ----------------
    assign w_diff     = s_axis_tdata - r_last_sample;
    assign w_prev     = (r_mode == MODE_TIMESTAMP) ? r_last_diff : r_last_sample;
    assign w_curr     = (r_mode == MODE_TIMESTAMP) ? w_diff : s_axis_tdata;
    assign w_shift    = w_sample_acc && (w_prev != w_curr);
    assign w_acc_next = {r_acc[6:0], w_prev > w_curr};
    assign w_push     = w_shift && (r_bit_cnt == 3'd7) && (r_fill != FILL_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample <= '0;
            r_last_diff   <= '0;
            r_acc         <= '0;
            r_bit_cnt     <= '0;
        end else if (w_sample_acc) begin
            r_last_sample <= s_axis_tdata;
            if (r_mode == MODE_TIMESTAMP) begin
                r_last_diff <= w_diff;
            end
            if (w_shift) begin
                r_acc     <= w_acc_next;
                r_bit_cnt <= r_bit_cnt + 3'd1;
            end
        end
    end

    // ---------------- pool fifo ----------------
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            mem[r_wr_ptr] <= w_acc_next;
        end
        if (w_pop) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                r_fill   <= r_fill + 1'b1;
            end else if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                r_fill   <= r_fill - 1'b1;
            end
        end
    end

    // ---------------- draw datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TIMESTAMP;
            r_seed <= '0;
            r_step <= '0;
            r_used <= '0;
        end else begin
            if (w_draw_acc) begin
                r_step <= '0;
                r_used <= '0;
            end
            if (r_state == ST_RED) begin
                r_seed <= w_pm_result;
                if (r_step != FINAL_STEP) begin
                    // fallback bytes land first-most-significant
                    r_bytes <= {r_bytes[23:0], w_pm_result[7:0]};
                    r_step  <= r_step + 3'd1;
                end
            end
            if (r_state == ST_POP && !w_pop) begin
                r_seed <= r_bytes;
                r_step <= FINAL_STEP;
            end
            if (w_pop_done) begin
                case (r_used[1:0])
                    2'd0:    r_bytes[31:24] <= r_rd_data;
                    2'd1:    r_bytes[23:16] <= r_rd_data;
                    2'd2:    r_bytes[15:8]  <= r_rd_data;
                    default: r_bytes[7:0]   <= r_rd_data;
                endcase
                r_used <= r_used + 3'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SOURCE_MODE: r_mode <= i_cfg_wdata[0];
                    REG_SEED_INIT:   r_seed <= i_cfg_wdata;
                    default:         r_mode <= r_mode;
                endcase
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value <= r_seed;
            r_out_used  <= r_used;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_used, r_out_value};

    // ---------------- assertions ----------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("pool fill above depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill == $past(r_fill) || r_fill == $past(r_fill) + 1'b1
                            || r_fill == $past(r_fill) - 1'b1))
        else $error("pool fill moved by more than one");

    a_sample_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sample_acc |=> r_state == ST_IDLE)
        else $error("sample tick left idle");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_used <= SEED_BYTES)
        else $error("more than four pool bytes used");

    a_no_push_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_push)
        else $error("push and pop in the same cycle");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// testbench for jitter_entropy_pool_with_lcg: drives sample ticks and draws on s_axis,
// predicts every draw result in a local model and checks m_axis against it
// depends on jep_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top
    import jep_pkg::*;
();

    localparam int POOL_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_WAIT   = 24;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  used;
    } t_draw_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    jitter_entropy_pool_with_lcg #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // collector and draw engine model
    logic        mode_q;
    logic [31:0] seed_q;
    logic [31:0] prev_sample;
    logic [31:0] prev_delta;
    logic [7:0]  acc_byte;
    int          acc_bits;
    logic [7:0]  pool_mem [POOL_DEPTH];
    int          pool_rd;
    int          pool_wr;
    int          pool_count;

    t_draw_result pending_draws[$];

    int  mismatch_count = 0;
    int  n_requests = 0;
    int  n_draws_checked = 0;
    int  n_pool_drops = 0;
    int  cycle_count = 0;
    int  hold_off = 0;
    bit  calm = 1'b0;
    logic [31:0] gen_last = '0;
    logic [31:0] gen_step = 32'd1000;

    function automatic logic [31:0] park_miller_next(input logic [31:0] s);
        logic [63:0] prod;
        prod = 64'(PM_MULT) * 64'(s);
        return 32'(prod % 64'(PM_MOD));
    endfunction

    function automatic void shift_compare(input logic [31:0] prev, input logic [31:0] curr);
        if (prev != curr) begin
            acc_byte = {acc_byte[6:0], prev > curr};
            acc_bits++;
            if (acc_bits == 8) begin
                acc_bits = 0;
                if (pool_count < POOL_DEPTH) begin
                    pool_mem[pool_wr] = acc_byte;
                    pool_wr = (pool_wr + 1) % POOL_DEPTH;
                    pool_count++;
                end else begin
                    n_pool_drops++;
                end
            end
        end
    endfunction

    function automatic void predict_request(input logic func, input logic [31:0] smp);
        logic [31:0]  delta;
        logic [31:0]  old;
        logic [7:0]   seed_bytes [4];
        logic [2:0]   used;
        t_draw_result res;
        if (func == FUNC_SAMPLE) begin
            if (mode_q == MODE_TIMESTAMP) begin
                delta = smp - prev_sample;
                old = prev_delta;
                prev_sample = smp;
                prev_delta = delta;
                shift_compare(old, delta);
            end else begin
                old = prev_sample;
                prev_sample = smp;
                shift_compare(old, smp);
            end
        end else begin
            used = '0;
            for (int i = 0; i < 4; i++) begin
                seed_q = park_miller_next(seed_q);
                seed_bytes[i] = seed_q[7:0];
            end
            // pool bytes replace fallback bytes from the first one on
            for (int i = 0; i < 4; i++) begin
                if (pool_count > 0) begin
                    seed_bytes[i] = pool_mem[pool_rd];
                    pool_rd = (pool_rd + 1) % POOL_DEPTH;
                    pool_count--;
                    used++;
                end
            end
            seed_q = park_miller_next({seed_bytes[0], seed_bytes[1], seed_bytes[2],
                                       seed_bytes[3]});
            res.value = seed_q;
            res.used = used;
            pending_draws.push_back(res);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called right after a rising edge; returns right after the accepting edge or the gap
    task automatic send_request(input logic func, input logic [31:0] smp);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(func, smp);
        n_requests++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_draws.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [31:0] data);
        wait_drained();
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == REG_SOURCE_MODE) mode_q = data[0];
        else seed_q = data;
    endtask

    function automatic logic [31:0] next_sample();
        int r;
        r = $urandom_range(0, 99);
        if (mode_q == MODE_TIMESTAMP) begin
            // jittered ticks: equal deltas happen often enough to skip bits
            if (r < 70) gen_step = 32'd1000 + $urandom_range(0, 3);
            else if (r < 85) gen_step = gen_step;
            else gen_step = $urandom;
            gen_last = gen_last + gen_step;
        end else begin
            if (r < 60) gen_last = gen_last + $urandom_range(0, 6) - 3;
            else if (r < 90) gen_last = $urandom;
            else gen_last = (r < 95) ? 32'h0 : 32'hFFFF_FFFF;
        end
        return gen_last;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_empty_pool_draws();
        // seed of zero stays zero, then the seed extremes with no pool bytes
        send_request(FUNC_DRAW, 32'h0);
        stop_sending();
        write_reg(REG_SEED_INIT, 32'h0000_0001);
        send_request(FUNC_DRAW, 32'hFFFF_FFFF);
        stop_sending();
        write_reg(REG_SEED_INIT, 32'hFFFF_FFFF);
        send_request(FUNC_DRAW, 32'h5555_AAAA);
        stop_sending();
        write_reg(REG_SEED_INIT, 32'h7FFF_FFFF);
        send_request(FUNC_DRAW, 32'h0);
        stop_sending();
        write_reg(REG_SEED_INIT, 32'h7FFF_FFFE);
    endtask

    task automatic test_sample_extremes();
        logic [31:0] ts_vals [10];
        logic [31:0] adc_vals [9];
        ts_vals = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
                    32'h8000_0000, 32'h8000_0001, 32'h8000_0002, 32'h7FFF_FFFF};
        adc_vals = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h0000_0FFF, 32'hAAAA_5555};
        foreach (ts_vals[i]) send_request(FUNC_SAMPLE, ts_vals[i]);
        send_request(FUNC_DRAW, 32'h0);
        stop_sending();
        write_reg(REG_SOURCE_MODE, MODE_ADC);
        foreach (adc_vals[i]) send_request(FUNC_SAMPLE, adc_vals[i]);
        send_request(FUNC_DRAW, 32'hFFFF_FFFF);
        stop_sending();
    endtask

    task automatic test_pool_overflow();
        logic [31:0] v;
        // every sample differs from the last one, so each gives a bit:
        // 66 bytes arrive and the last two meet a full pool
        write_reg(REG_SOURCE_MODE, MODE_ADC);
        write_reg(REG_SEED_INIT, $urandom);
        calm = 1'b1;
        for (int i = 0; i < 528; i++) begin
            do v = $urandom; while (v == prev_sample);
            send_request(FUNC_SAMPLE, v);
        end
        calm = 1'b0;
        for (int i = 0; i < 17; i++) send_request(FUNC_DRAW, $urandom);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_output_stall();
        // long receiver hold-off: a finished draw parks, the next one blocks the input
        write_reg(REG_SOURCE_MODE, MODE_TIMESTAMP);
        hold_off = 400;
        for (int k = 0; k < 3; k++) begin
            send_request(FUNC_DRAW, $urandom);
            for (int i = 0; i < 8; i++) send_request(FUNC_SAMPLE, next_sample());
        end
        send_request(FUNC_DRAW, $urandom);
        stop_sending();
        // sender waits for every result before going on
        wait_drained();
        for (int i = 0; i < 12; i++) send_request(FUNC_SAMPLE, next_sample());
        send_request(FUNC_DRAW, $urandom);
        stop_sending();
    endtask

    task automatic test_random_traffic();
        int draw_odds;
        logic [31:0] seed_pick;
        for (int chunk = 0; chunk < 6; chunk++) begin
            write_reg(REG_SOURCE_MODE, chunk[0]);
            case ($urandom_range(0, 4))
                0: seed_pick = 32'h0;
                1: seed_pick = 32'hFFFF_FFFF;
                2: seed_pick = 32'h7FFF_FFFF;
                default: seed_pick = $urandom;
            endcase
            write_reg(REG_SEED_INIT, seed_pick);
            calm = (chunk == 2);
            draw_odds = (chunk < 3) ? 4 : 6;
            for (int i = 0; i < 8; i++) begin
                if ($urandom_range(1, draw_odds) == 1) send_request(FUNC_DRAW, $urandom);
                else send_request(FUNC_SAMPLE, next_sample());
            end
            calm = 1'b0;
            stop_sending();
        end
    endtask

    // ------------------------------------------------------- result side

    initial begin : ready_gen
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_off > 0) begin
                n = hold_off;
                hold_off = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_draw_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_draws.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected draw result: value %h used %0d",
                             m_axis_tdata[31:0], m_axis_tdata[34:32]);
            end else begin
                want = pending_draws.pop_front();
                if (m_axis_tdata[31:0] !== want.value || m_axis_tdata[34:32] !== want.used) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("draw %0d mismatch: expected value %h used %0d, got value %h used %0d",
                                 n_draws_checked, want.value, want.used,
                                 m_axis_tdata[31:0], m_axis_tdata[34:32]);
                end
                n_draws_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------- main

    initial begin
        mode_q = MODE_TIMESTAMP;
        seed_q = '0;
        prev_sample = '0;
        prev_delta = '0;
        acc_byte = '0;
        acc_bits = 0;
        pool_rd = 0;
        pool_wr = 0;
        pool_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pool_draws();
        test_sample_extremes();
        test_pool_overflow();
        test_output_stall();
        test_random_traffic();

        wait_drained();
        repeat (IDLE_WAIT) @(posedge i_clk);
        mismatch_count += pending_draws.size();

        $display("ran %0d requests in both source modes, checked %0d draws", n_requests,
                 n_draws_checked);
        $display("pool overflow dropped %0d bytes, mismatches %0d", n_pool_drops,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/jep_pkg.sv
hw/rtl/jep_pm_unit.sv
hw/rtl/jitter_entropy_pool_with_lcg.sv
sim/tb_top.sv
